// ----- src/ucr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucr_pkg
// Shared sizes, item types and control types of the cosine top-k recommender.
// ----------------------------------------------------------------------------
package ucr_pkg;

    localparam int USER_COUNT  = 64;
    localparam int MOVIE_COUNT = 256;
    localparam int TOP_COUNT   = 5;

    localparam int MAX_RATING = 10;
    localparam int RATING_W   = 4;
    localparam int IN_USER_W  = 6;
    localparam int IN_MOVIE_W = 8;
    localparam int SCORE_W    = 20;
    localparam int SIM_W      = 16;
    localparam int SIM_BITS   = SIM_W + 1;

    localparam int USER_W  = $clog2(USER_COUNT);
    localparam int MOVIE_W = (MOVIE_COUNT > 1) ? $clog2(MOVIE_COUNT) : 1;
    localparam int DEPTH   = USER_COUNT * MOVIE_COUNT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int NORM_W  = $clog2(MOVIE_COUNT * MAX_RATING * MAX_RATING + 1);
    localparam int DOT_W   = NORM_W;
    localparam int P_W     = 2 * NORM_W;
    localparam int D2_W    = 2 * DOT_W;
    localparam int SP_W    = P_W + SIM_BITS;
    localparam int SQP_W   = P_W + 2 * SIM_BITS + 2;
    localparam int BIT_W   = $clog2(SIM_BITS);
    localparam int CNT_W   = $clog2(TOP_COUNT + 1);
    localparam int IDX_W   = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [IN_USER_W-1:0]  user_index;
        logic [IN_MOVIE_W-1:0] movie_index;
        logic [RATING_W-1:0]   rating_half;
    } in_item_t;

    typedef struct packed {
        logic [IN_MOVIE_W-1:0] movie_index_out;
        logic [SCORE_W-1:0]    score;
        logic                  last;
        logic                  none_found;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_READ,
        ST_LD_WRITE,
        ST_Q_START,
        ST_U_CHECK,
        ST_DOT,
        ST_DOT_WAIT,
        ST_SIM_INIT,
        ST_SIM_A,
        ST_SIM_B,
        ST_SIM_DONE,
        ST_SCAN,
        ST_DRAIN,
        ST_NEXT_U,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               item_load;
        logic               clear;
        logic [ADDR_W-1:0]  clear_addr;
        logic               ld_wr;
        logic               norm_rd;
        logic               dot_clr;
        logic               sweep_dot;
        logic               sweep_scan;
        logic               sim_init;
        logic               sim_step_a;
        logic               sim_step_b;
        logic [BIT_W-1:0]   sim_bit;
        logic               top_clr;
        logic               out_load;
        logic [IDX_W-1:0]   out_idx;
        logic [USER_W-1:0]  user;
        logic [MOVIE_W-1:0] movie;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_kind;
        logic ld_ok;
        logic target_ok;
        logic is_target;
        logic norm_zero;
        logic sim_zero;
        logic out_free;
        logic last_idx;
    } dp_status_t;

    function automatic logic [ADDR_W-1:0] store_addr(logic [USER_W-1:0] u,
                                                     logic [MOVIE_W-1:0] m);
        return ADDR_W'(u) * ADDR_W'(MOVIE_COUNT) + ADDR_W'(m);
    endfunction

endpackage

// ----- src/user_cosine_topk_recommender_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// user_cosine_topk_recommender_unit
// User-based collaborative filtering: cosine similarity, best five pairs.
// ----------------------------------------------------------------------------
//  Channel | Ports                      | Moves
//  --------+----------------------------+-----------------------------------
//  input   | s_valid, s_ready, s_data   | one load or query per transfer
//  result  | m_valid, m_ready, m_data   | one ranked pair per transfer
//
//  After reset the rating store is cleared, one entry a cycle; s_ready
//  stays low until then.
//  A load accepts the item, reads the old rating and norm, then writes back.
//  A query walks every other user: a dot-product sweep over the store, a
//  bit-serial cosine (a trial step and a decide step per result bit), then a
//  candidate scan when the similarity is positive, and a step to the next user.
//  Results leave through an output register; a stall on m_ready only holds it.
// ----------------------------------------------------------------------------
module user_cosine_topk_recommender_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ucr_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ucr_pkg::out_item_t   m_data
);

    ucr_pkg::ctrl_cmd_t  cmd;
    ucr_pkg::dp_status_t st;

    ucr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ucr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .st      (st)
    );

endmodule

// ----- src/ucr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucr_ctrl
// Sequencer: clearing pass, rating loads, and the per-user query walk.
// ----------------------------------------------------------------------------
module ucr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ucr_pkg::dp_status_t    st,
    output ucr_pkg::ctrl_cmd_t     cmd
);

    ucr_pkg::state_t                  state_reg, state_next;
    logic [ucr_pkg::ADDR_W-1:0]       clr_reg, clr_next;
    logic [ucr_pkg::USER_W-1:0]       user_reg, user_next;
    logic [ucr_pkg::MOVIE_W-1:0]      movie_reg, movie_next;
    logic [ucr_pkg::BIT_W-1:0]        bit_reg, bit_next;
    logic [ucr_pkg::IDX_W-1:0]        out_reg, out_next;
    logic                             drain_reg, drain_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ucr_pkg::ST_CLEAR;
            clr_reg   <= '0;
            user_reg  <= '0;
            movie_reg <= '0;
            bit_reg   <= '0;
            out_reg   <= '0;
            drain_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            user_reg  <= user_next;
            movie_reg <= movie_next;
            bit_reg   <= bit_next;
            out_reg   <= out_next;
            drain_reg <= drain_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        user_next  = user_reg;
        movie_next = movie_reg;
        bit_next   = bit_reg;
        out_next   = out_reg;
        drain_next = drain_reg;
        s_ready    = 1'b0;
        cmd            = '0;
        cmd.clear_addr = clr_reg;
        cmd.user       = user_reg;
        cmd.movie      = movie_reg;
        cmd.sim_bit    = bit_reg;
        cmd.out_idx    = out_reg;

        unique case (state_reg)
            ucr_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ucr_pkg::ADDR_W'(ucr_pkg::DEPTH - 1)) begin
                    state_next = ucr_pkg::ST_IDLE;
                end
            end
            ucr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next = (st.in_kind == ucr_pkg::KIND_QUERY) ?
                                 ucr_pkg::ST_Q_START : ucr_pkg::ST_LD_READ;
                end
            end
            ucr_pkg::ST_LD_READ: begin
                cmd.norm_rd = 1'b1;
                state_next  = st.ld_ok ? ucr_pkg::ST_LD_WRITE : ucr_pkg::ST_IDLE;
            end
            ucr_pkg::ST_LD_WRITE: begin
                cmd.ld_wr  = 1'b1;
                state_next = ucr_pkg::ST_IDLE;
            end
            ucr_pkg::ST_Q_START: begin
                cmd.top_clr = 1'b1;
                user_next   = '0;
                out_next    = '0;
                state_next  = st.target_ok ? ucr_pkg::ST_U_CHECK : ucr_pkg::ST_OUT;
            end
            ucr_pkg::ST_U_CHECK: begin
                if (st.is_target) begin
                    state_next = ucr_pkg::ST_NEXT_U;
                end else begin
                    cmd.norm_rd = 1'b1;
                    cmd.dot_clr = 1'b1;
                    movie_next  = '0;
                    state_next  = ucr_pkg::ST_DOT;
                end
            end
            ucr_pkg::ST_DOT: begin
                cmd.sweep_dot = 1'b1;
                movie_next    = movie_reg + 1'b1;
                if (movie_reg == ucr_pkg::MOVIE_W'(ucr_pkg::MOVIE_COUNT - 1)) begin
                    movie_next = '0;
                    state_next = ucr_pkg::ST_DOT_WAIT;
                end
            end
            ucr_pkg::ST_DOT_WAIT: begin
                state_next = ucr_pkg::ST_SIM_INIT;
            end
            ucr_pkg::ST_SIM_INIT: begin
                cmd.sim_init = 1'b1;
                bit_next     = ucr_pkg::BIT_W'(ucr_pkg::SIM_BITS - 1);
                state_next   = st.norm_zero ? ucr_pkg::ST_NEXT_U : ucr_pkg::ST_SIM_A;
            end
            ucr_pkg::ST_SIM_A: begin
                cmd.sim_step_a = 1'b1;
                state_next     = ucr_pkg::ST_SIM_B;
            end
            ucr_pkg::ST_SIM_B: begin
                cmd.sim_step_b = 1'b1;
                if (bit_reg == '0) begin
                    state_next = ucr_pkg::ST_SIM_DONE;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ucr_pkg::ST_SIM_A;
                end
            end
            ucr_pkg::ST_SIM_DONE: begin
                movie_next = '0;
                state_next = st.sim_zero ? ucr_pkg::ST_NEXT_U : ucr_pkg::ST_SCAN;
            end
            ucr_pkg::ST_SCAN: begin
                cmd.sweep_scan = 1'b1;
                movie_next     = movie_reg + 1'b1;
                if (movie_reg == ucr_pkg::MOVIE_W'(ucr_pkg::MOVIE_COUNT - 1)) begin
                    movie_next = '0;
                    drain_next = 1'b0;
                    state_next = ucr_pkg::ST_DRAIN;
                end
            end
            ucr_pkg::ST_DRAIN: begin
                // The drain state lets the last candidates reach the ranking registers.
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ucr_pkg::ST_NEXT_U;
                end
            end
            ucr_pkg::ST_NEXT_U: begin
                if (user_reg == ucr_pkg::USER_W'(ucr_pkg::USER_COUNT - 1)) begin
                    state_next = ucr_pkg::ST_OUT;
                end else begin
                    user_next  = user_reg + 1'b1;
                    state_next = ucr_pkg::ST_U_CHECK;
                end
            end
            ucr_pkg::ST_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    if (st.last_idx) begin
                        state_next = ucr_pkg::ST_IDLE;
                    end else begin
                        out_next = out_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ucr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/ucr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucr_datapath
// Rating and norm stores, dot product, bit-serial cosine, ranking, output.
// ----------------------------------------------------------------------------
module ucr_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ucr_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ucr_pkg::out_item_t    m_data,
    input  ucr_pkg::ctrl_cmd_t    cmd,
    output ucr_pkg::dp_status_t   st
);

    logic [ucr_pkg::RATING_W-1:0] rating_mem [ucr_pkg::DEPTH];
    logic [ucr_pkg::NORM_W-1:0]   norm_mem [ucr_pkg::USER_COUNT];

    ucr_pkg::in_item_t            item_reg;
    logic [ucr_pkg::RATING_W-1:0] rd_a_reg, rd_b_reg;
    logic [ucr_pkg::NORM_W-1:0]   na_reg, nb_reg;

    logic [ucr_pkg::USER_W-1:0]   tgt_user, ld_user;
    logic [ucr_pkg::ADDR_W-1:0]   addr_a, addr_b, wr_addr;
    logic [ucr_pkg::RATING_W-1:0] rating_sat, wr_rating;
    logic [ucr_pkg::NORM_W-1:0]   norm_new, wr_norm;
    logic [ucr_pkg::USER_W-1:0]   norm_wr_addr;
    logic                         mem_we;

    logic                         dot_v_reg, scan_v_reg, c_v_reg;
    logic [ucr_pkg::MOVIE_W-1:0]  movie_d_reg, c_movie_reg;
    logic [ucr_pkg::SCORE_W-1:0]  c_score_reg;
    logic [ucr_pkg::DOT_W-1:0]    dot_reg;

    logic [ucr_pkg::P_W-1:0]      p_reg;
    logic [ucr_pkg::D2_W-1:0]     d2_reg;
    logic [ucr_pkg::SIM_BITS-1:0] s_reg;
    logic [ucr_pkg::SQP_W-1:0]    sqp_reg, trial_sqp_reg, trial_sqp_next;
    logic [ucr_pkg::SP_W-1:0]     sp_reg, trial_sp_reg, trial_sp_next;
    logic [ucr_pkg::SIM_W-1:0]    sim_q;

    logic [ucr_pkg::SCORE_W-1:0]  best_score_reg [ucr_pkg::TOP_COUNT];
    logic [ucr_pkg::MOVIE_W-1:0]  best_movie_reg [ucr_pkg::TOP_COUNT];
    logic [ucr_pkg::CNT_W-1:0]    count_reg;
    logic                         ins_found;
    logic [ucr_pkg::IDX_W-1:0]    ins_pos;

    logic                         m_valid_reg;
    ucr_pkg::out_item_t           m_data_reg;
    logic                         none_q;

    assign tgt_user   = ucr_pkg::USER_W'(item_reg.user_index);
    assign ld_user    = tgt_user;
    assign rating_sat = (item_reg.rating_half > ucr_pkg::RATING_W'(ucr_pkg::MAX_RATING)) ?
                        ucr_pkg::RATING_W'(ucr_pkg::MAX_RATING) : item_reg.rating_half;

    assign addr_a = (cmd.sweep_dot || cmd.sweep_scan) ?
                    ucr_pkg::store_addr(tgt_user, cmd.movie) :
                    ucr_pkg::store_addr(ld_user,
                                        ucr_pkg::MOVIE_W'(item_reg.movie_index));
    assign addr_b = ucr_pkg::store_addr(cmd.user, cmd.movie);

    // The old rating and the old norm were read in the cycle before the write.
    assign norm_new = na_reg
                    - ucr_pkg::NORM_W'(rd_a_reg) * ucr_pkg::NORM_W'(rd_a_reg)
                    + ucr_pkg::NORM_W'(rating_sat) * ucr_pkg::NORM_W'(rating_sat);

    assign mem_we       = cmd.clear || cmd.ld_wr;
    assign wr_addr      = cmd.clear ? cmd.clear_addr : addr_a;
    assign wr_rating    = cmd.clear ? '0 : rating_sat;
    assign wr_norm      = cmd.clear ? '0 : norm_new;
    assign norm_wr_addr = cmd.clear ? cmd.clear_addr[ucr_pkg::USER_W-1:0] : ld_user;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rating_mem[wr_addr]    <= wr_rating;
            norm_mem[norm_wr_addr] <= wr_norm;
        end
        rd_a_reg <= rating_mem[addr_a];
        rd_b_reg <= rating_mem[addr_b];
        if (cmd.norm_rd) begin
            na_reg <= norm_mem[tgt_user];
            nb_reg <= norm_mem[cmd.user];
        end
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
    end

    // Dot product and candidate pipeline.
    assign sim_q = s_reg[ucr_pkg::SIM_BITS-1] ? '1 : s_reg[ucr_pkg::SIM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_v_reg  <= 1'b0;
            scan_v_reg <= 1'b0;
            c_v_reg    <= 1'b0;
        end else begin
            dot_v_reg  <= cmd.sweep_dot;
            scan_v_reg <= cmd.sweep_scan;
            c_v_reg    <= scan_v_reg && (rd_a_reg == '0) && (rd_b_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        movie_d_reg <= cmd.movie;
        c_movie_reg <= movie_d_reg;
        c_score_reg <= ucr_pkg::SCORE_W'(rd_b_reg) * ucr_pkg::SCORE_W'(sim_q);
        if (cmd.dot_clr) begin
            dot_reg <= '0;
        end else if (dot_v_reg) begin
            dot_reg <= dot_reg + ucr_pkg::DOT_W'(rd_a_reg) * ucr_pkg::DOT_W'(rd_b_reg);
        end
    end

    // Cosine, one result bit per trial step and decide step. s*P and s*s*P are kept up to date
    // with shifts and adds, so the trial of bit k needs no multiplier.
    assign trial_sqp_next = sqp_reg
                          + (ucr_pkg::SQP_W'(sp_reg) << (cmd.sim_bit + 1'b1))
                          + (ucr_pkg::SQP_W'(p_reg) << {cmd.sim_bit, 1'b0});
    assign trial_sp_next  = sp_reg + (ucr_pkg::SP_W'(p_reg) << cmd.sim_bit);

    always_ff @(posedge aclk) begin
        if (cmd.sim_init) begin
            p_reg   <= ucr_pkg::P_W'(na_reg) * ucr_pkg::P_W'(nb_reg);
            d2_reg  <= ucr_pkg::D2_W'(dot_reg) * ucr_pkg::D2_W'(dot_reg);
            s_reg   <= '0;
            sqp_reg <= '0;
            sp_reg  <= '0;
        end else if (cmd.sim_step_a) begin
            trial_sqp_reg <= trial_sqp_next;
            trial_sp_reg  <= trial_sp_next;
        end else if (cmd.sim_step_b) begin
            if (trial_sqp_reg <= (ucr_pkg::SQP_W'(d2_reg) << (2 * ucr_pkg::SIM_W))) begin
                s_reg[cmd.sim_bit] <= 1'b1;
                sqp_reg            <= trial_sqp_reg;
                sp_reg             <= trial_sp_reg;
            end
        end
    end

    // Ranking: insert ahead of the first strictly smaller entry, so that equal
    // scores keep the order in which they arrived.
    always_comb begin
        ins_found = 1'b0;
        ins_pos   = '0;
        for (int i = 0; i < ucr_pkg::TOP_COUNT; i++) begin
            if (!ins_found && ((ucr_pkg::CNT_W'(i) >= count_reg) ||
                               (c_score_reg > best_score_reg[i]))) begin
                ins_found = 1'b1;
                ins_pos   = ucr_pkg::IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.top_clr) begin
            count_reg <= '0;
        end else if (c_v_reg && ins_found &&
                     (count_reg != ucr_pkg::CNT_W'(ucr_pkg::TOP_COUNT))) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_v_reg && ins_found) begin
            for (int i = 0; i < ucr_pkg::TOP_COUNT; i++) begin
                if (ucr_pkg::IDX_W'(i) == ins_pos) begin
                    best_score_reg[i] <= c_score_reg;
                    best_movie_reg[i] <= c_movie_reg;
                end else if ((i > 0) && (ucr_pkg::IDX_W'(i) > ins_pos)) begin
                    best_score_reg[i] <= best_score_reg[(i == 0) ? 0 : i - 1];
                    best_movie_reg[i] <= best_movie_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Output register.
    assign none_q = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.movie_index_out <= none_q ? '0 :
                ucr_pkg::IN_MOVIE_W'(best_movie_reg[cmd.out_idx]);
            m_data_reg.score      <= none_q ? '0 : best_score_reg[cmd.out_idx];
            m_data_reg.last       <= st.last_idx;
            m_data_reg.none_found <= none_q;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign st.in_kind   = s_data.kind;
    assign st.ld_ok     = (32'(item_reg.user_index) < ucr_pkg::USER_COUNT) &&
                          (32'(item_reg.movie_index) < ucr_pkg::MOVIE_COUNT);
    assign st.target_ok = 32'(item_reg.user_index) < ucr_pkg::USER_COUNT;
    assign st.is_target = 32'(cmd.user) == 32'(item_reg.user_index);
    assign st.norm_zero = (na_reg == '0) || (nb_reg == '0);
    assign st.sim_zero  = (s_reg == '0);
    assign st.out_free  = !m_valid_reg || m_ready;
    assign st.last_idx  = none_q || (ucr_pkg::CNT_W'(cmd.out_idx) + 1'b1 == count_reg);

endmodule

// ----- src/ucr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucr_checker
// Port-level checks of the recommender, bound to the top level.
// ----------------------------------------------------------------------------
module ucr_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input ucr_pkg::in_item_t    s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input ucr_pkg::out_item_t   m_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The store is being cleared right after reset.
    a_clear_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during clearing pass");

    // An empty answer is a single, final, all-zero transfer.
    a_none_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.none_found |->
            m_data.last && (m_data.score == '0) && (m_data.movie_index_out == '0))
        else $error("malformed empty answer");

    // A query keeps the input closed while it walks the store.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == ucr_pkg::KIND_QUERY) |=> !s_ready)
        else $error("input ready right after a query");

endmodule

bind user_cosine_topk_recommender_unit ucr_checker u_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Rating loads and top-five queries against a cosine similarity predictor.
// A directed table covers the extremes and the corner cases of loads and
// queries. Random rating sets on a few users follow, each closed by queries.
// Every result transfer is compared with the oldest predicted ranking entry.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 200000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ucr_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ucr_pkg::out_item_t m_data;

    user_cosine_topk_recommender_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state.
    logic [ucr_pkg::RATING_W-1:0] ratings [ucr_pkg::USER_COUNT][ucr_pkg::MOVIE_COUNT];
    longint             user_norm [ucr_pkg::USER_COUNT];
    ucr_pkg::out_item_t pending_results [$];
    int                 fail_count = 0;
    int                 idle_cycles = 0;
    bit                 hold_off = 1'b0;
    bit                 stim_done = 1'b0;

    // Floor of 65536 * dot / sqrt(prod), saturated, by bisection in integers.
    function automatic int cosine_sim(int a, int b);
        longint dot, prod, lo, hi, mid;
        logic [127:0] lhs, rhs;
        dot = 0;
        if (user_norm[a] == 0 || user_norm[b] == 0) return 0;
        for (int m = 0; m < ucr_pkg::MOVIE_COUNT; m++)
            dot += longint'(ratings[a][m]) * longint'(ratings[b][m]);
        prod = user_norm[a] * user_norm[b];
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = 128'(mid) * 128'(mid) * 128'(prod);
            rhs = (128'(dot) * 128'(dot)) << 32;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return (lo > 65535) ? 65535 : int'(lo);
    endfunction

    task automatic predict_item(input ucr_pkg::in_item_t it);
        int best_s [ucr_pkg::TOP_COUNT];
        int best_m [ucr_pkg::TOP_COUNT];
        int cnt, p, sim, sc, r, t;
        ucr_pkg::out_item_t res;
        cnt = 0;
        if (it.kind == ucr_pkg::KIND_LOAD) begin
            if (it.user_index < ucr_pkg::USER_COUNT &&
                it.movie_index < ucr_pkg::MOVIE_COUNT) begin
                r = (it.rating_half > ucr_pkg::MAX_RATING) ?
                    ucr_pkg::MAX_RATING : int'(it.rating_half);
                t = int'(ratings[it.user_index][it.movie_index]);
                user_norm[it.user_index] += r * r - t * t;
                ratings[it.user_index][it.movie_index] = ucr_pkg::RATING_W'(r);
            end
            return;
        end
        t = int'(it.user_index);
        if (t < ucr_pkg::USER_COUNT) begin
            for (int u = 0; u < ucr_pkg::USER_COUNT; u++) begin
                if (u == t) continue;
                sim = cosine_sim(t, u);
                if (sim == 0) continue;
                for (int m = 0; m < ucr_pkg::MOVIE_COUNT; m++) begin
                    if (ratings[t][m] != 0 || ratings[u][m] == 0) continue;
                    sc = int'(ratings[u][m]) * sim;
                    // Strictly greater keeps earlier users and movies ahead on ties.
                    if (cnt < ucr_pkg::TOP_COUNT) begin
                        p = cnt;
                        cnt++;
                    end else if (sc > best_s[ucr_pkg::TOP_COUNT-1]) begin
                        p = ucr_pkg::TOP_COUNT - 1;
                    end else begin
                        continue;
                    end
                    while (p > 0 && sc > best_s[p-1]) begin
                        best_s[p] = best_s[p-1];
                        best_m[p] = best_m[p-1];
                        p--;
                    end
                    best_s[p] = sc;
                    best_m[p] = m;
                end
            end
        end
        if (cnt == 0) begin
            res = '0;
            res.last = 1'b1;
            res.none_found = 1'b1;
            pending_results.push_back(res);
        end
        for (int k = 0; k < cnt; k++) begin
            res.movie_index_out = ucr_pkg::IN_MOVIE_W'(best_m[k]);
            res.score = ucr_pkg::SCORE_W'(best_s[k]);
            res.last = (k + 1 == cnt);
            res.none_found = 1'b0;
            pending_results.push_back(res);
        end
    endtask

    // Sender: one item per call, held until the transfer happens.
    task automatic offer_item(input ucr_pkg::in_item_t it);
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_item(input ucr_pkg::in_item_t it);
        offer_item(it);
        predict_item(it);
    endtask

    task automatic maybe_gap();
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic ucr_pkg::in_item_t make_item(bit k, int u, int m, int r);
        ucr_pkg::in_item_t it;
        it.kind = k;
        it.user_index = ucr_pkg::IN_USER_W'(u);
        it.movie_index = ucr_pkg::IN_MOVIE_W'(m);
        it.rating_half = ucr_pkg::RATING_W'(r);
        return it;
    endfunction

    // Directed rows; expected results hand-entered where obvious. Rows with a
    // hand-entered result are queries, so they leave the predictor state alone.
    typedef struct {
        ucr_pkg::in_item_t  item;
        bit                 fixed;
        ucr_pkg::out_item_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic ucr_pkg::out_item_t none_result();
        ucr_pkg::out_item_t r;
        r = '0;
        r.last = 1'b1;
        r.none_found = 1'b1;
        return r;
    endfunction

    initial begin
        ucr_pkg::out_item_t got_none;
        ucr_pkg::in_item_t it;
        int users [4];
        int u, n;
        foreach (ratings[i, j]) ratings[i][j] = '0;
        foreach (user_norm[i]) user_norm[i] = 0;
        got_none = none_result();
        // Empty store gives none_found for any user.
        dir_rows.push_back('{make_item(ucr_pkg::KIND_QUERY, 0, 0, 0), 1'b1, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_QUERY, 63, 255, 15), 1'b1, got_none});
        // Extremes of the load fields, rating above range saturates.
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 63, 255, 15), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 0, 255, 10), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 0, 0, 1), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 63, 0, 5), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_QUERY, 0, 0, 0), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_QUERY, 63, 0, 0), 1'b0, got_none});
        // Tie: two users with identical ratings give equal scores.
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 1, 0, 1), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 1, 7, 8), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 2, 0, 1), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 2, 7, 8), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_QUERY, 0, 0, 0), 1'b0, got_none});
        // Clearing a rating and the user that rated nothing else.
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 63, 255, 0), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_LOAD, 63, 0, 0), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_QUERY, 63, 128, 10), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_QUERY, 1, 0, 0), 1'b0, got_none});
        dir_rows.push_back('{make_item(ucr_pkg::KIND_QUERY, 2, 0, 0), 1'b0, got_none});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            offer_item(dir_rows[i].item);
            if (dir_rows[i].fixed)
                pending_results.push_back(dir_rows[i].want);
            else
                predict_item(dir_rows[i].item);
        end
        s_valid <= 1'b0;
        // Pause until everything has drained.
        while (pending_results.size() != 0) @(posedge aclk);

        // Random part: rating sets over a few users, each closed by queries.
        n = 0;
        while (n < 140) begin
            for (int k = 0; k < 4; k++) users[k] = $urandom_range(0, 63);
            repeat ($urandom_range(8, 20)) begin
                u = users[$urandom_range(0, 3)];
                if ($urandom_range(0, 9) == 0)
                    it = make_item(ucr_pkg::KIND_LOAD, $urandom, $urandom, $urandom);
                else
                    it = make_item(ucr_pkg::KIND_LOAD, u, $urandom_range(0, 15),
                                   $urandom_range(0, 15));
                send_item(it);
                n++;
                maybe_gap();
            end
            repeat ($urandom_range(1, 3)) begin
                it = make_item(ucr_pkg::KIND_QUERY, users[$urandom_range(0, 3)],
                               $urandom, $urandom);
                if ($urandom_range(0, 7) == 0)
                    it.user_index = ucr_pkg::IN_USER_W'($urandom);
                send_item(it);
                n++;
                maybe_gap();
            end
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus a long hold-off whenever three or more results are pending.
    initial begin
        int hold_count;
        hold_count = 0;
        forever begin
            @(posedge aclk);
            if (!hold_off && hold_count == 0 && pending_results.size() >= 3) begin
                hold_off = 1'b1;
                hold_count = 600;
            end
            if (hold_count > 0) begin
                hold_count--;
                if (hold_count == 0) hold_off = 1'b0;
            end
            m_ready <= hold_off ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    // Result checking.
    always @(posedge aclk) begin
        ucr_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %p", m_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.movie_index_out !== want.movie_index_out) begin
                    $error("movie_index_out expected %0d got %0d",
                           want.movie_index_out, m_data.movie_index_out);
                    fail_count++;
                end
                if (m_data.score !== want.score) begin
                    $error("score expected %0d got %0d", want.score, m_data.score);
                    fail_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last expected %0d got %0d", want.last, m_data.last);
                    fail_count++;
                end
                if (m_data.none_found !== want.none_found) begin
                    $error("none_found expected %0d got %0d",
                           want.none_found, m_data.none_found);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog counts cycles without any transfer; reset clear pass included.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (stim_done);
        while (pending_results.size() != 0 && idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
        end else begin
            repeat (200) @(posedge aclk);
            if (fail_count == 0 && pending_results.size() == 0)
                $display("PASSED: all results match");
            else
                $display("FAILED: results differ");
        end
        $finish;
    end

    // Timeout before the stimulus completes.
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT && !stim_done);
        $display("FAILED: results differ");
        $finish;
    end
endmodule
